FILE: hdl/lzss_pkg.sv
// Shared constants and types of the LZSS bitstream decoder.
`timescale 1ns / 1ps
`default_nettype none
package lzss_pkg;

	localparam int POS_BITS   = 13;
	localparam int LEN_BITS   = 4;
	localparam int LIT_BITS   = 8;
	localparam int MIN_MATCH  = 3;
	localparam int DICT_DEPTH = 1 << POS_BITS;
	localparam int CNT_BITS   = LEN_BITS + 1;
	localparam int REM_BITS   = $clog2(POS_BITS + 1);

	typedef logic [POS_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [REM_BITS-1:0] rem_t;
	typedef logic [LIT_BITS-1:0] byte_t;

	// Token kinds passed from the bit reader to the copy control.
	localparam logic [1:0] TOK_LIT   = 2'd0;
	localparam logic [1:0] TOK_MATCH = 2'd1;
	localparam logic [1:0] TOK_END   = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		addr_t               pos;
		logic [LEN_BITS-1:0] len;
		byte_t               lit;
	} tok_t;

endpackage
`default_nettype wire

FILE: hdl/lzss_history.sv
// History dictionary: one synchronous RAM with fill tracking and write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none
module lzss_history (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           we,
	input  wire lzss_pkg::addr_t waddr,
	input  wire lzss_pkg::byte_t wdata,
	input  wire logic           re,
	input  wire lzss_pkg::addr_t raddr,
	output lzss_pkg::byte_t     rdata
);

	lzss_pkg::byte_t mem [lzss_pkg::DICT_DEPTH];
	lzss_pkg::byte_t mem_rd_s1;
	lzss_pkg::byte_t fwd_data_s1;
	logic            fwd_s1;
	logic            vld_s1;
	lzss_pkg::addr_t hw_q;
	logic            full_q;

	// Writes run upward from one; entry zero is written only after a full wrap.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			mem_rd_s1   <= mem[raddr];
			fwd_data_s1 <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q   <= '0;
			full_q <= 1'b0;
			fwd_s1 <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				if (waddr == '0)
					full_q <= 1'b1;
				else if (waddr > hw_q)
					hw_q <= waddr;
			end
			if (re) begin
				fwd_s1 <= we && (waddr == raddr);
				vld_s1 <= full_q || ((raddr != '0) && (raddr <= hw_q));
			end
		end
	end

	// Never-written entries read as zero, matching the cleared dictionary.
	always_comb begin
		if (fwd_s1)
			rdata = fwd_data_s1;
		else if (vld_s1)
			rdata = mem_rd_s1;
		else
			rdata = '0;
	end

endmodule
`default_nettype wire

FILE: hdl/lzss_bit_reader.sv
// Bit-serial token parser (literal, match, end): one bit per cycle unless a token waits.
`timescale 1ns / 1ps
`default_nettype none
module lzss_bit_reader (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire lzss_pkg::byte_t in_byte,
	output logic                 in_ready,
	output logic                 tok_valid,
	output lzss_pkg::tok_t       tok,
	input  wire logic            tok_ready
);

	localparam logic [1:0] ST_FLAG = 2'd0;
	localparam logic [1:0] ST_LIT  = 2'd1;
	localparam logic [1:0] ST_POS  = 2'd2;
	localparam logic [1:0] ST_LEN  = 2'd3;

	logic [1:0]      stage_q, stage_nx;
	lzss_pkg::byte_t sh_q, sh_nx;
	logic [3:0]      bits_q, bits_nx;
	lzss_pkg::addr_t acc_q, acc_nx, acc_sh;
	lzss_pkg::rem_t  rem_q, rem_nx, rem_dec;
	lzss_pkg::addr_t saved_q, saved_nx;
	logic            tok_valid_q;
	lzss_pkg::tok_t  tok_q, tok_nx;
	logic            tok_set;
	logic            go;
	logic            bit_now;

	assign in_ready  = (bits_q == '0);
	assign tok_valid = tok_valid_q;
	assign tok       = tok_q;

	// Hold while a finished token waits to be taken.
	assign go      = (bits_q != '0) && !(tok_valid_q && !tok_ready);
	assign bit_now = sh_q[7];
	assign acc_sh  = {acc_q[lzss_pkg::POS_BITS-2:0], bit_now};
	assign rem_dec = (rem_q != '0) ? rem_q - lzss_pkg::rem_t'(1) : rem_q;

	always_comb begin
		stage_nx = stage_q;
		sh_nx    = sh_q;
		bits_nx  = bits_q;
		acc_nx   = acc_q;
		rem_nx   = rem_q;
		saved_nx = saved_q;
		tok_nx   = tok_q;
		tok_set  = 1'b0;
		if (in_valid && in_ready) begin
			sh_nx   = in_byte;
			bits_nx = 4'd8;
		end else if (go) begin
			sh_nx   = {sh_q[6:0], 1'b0};
			bits_nx = bits_q - 4'd1;
			unique case (stage_q)
				ST_FLAG: begin
					acc_nx = '0;
					if (bit_now) begin
						stage_nx = ST_LIT;
						rem_nx   = lzss_pkg::rem_t'(lzss_pkg::LIT_BITS);
					end else begin
						stage_nx = ST_POS;
						rem_nx   = lzss_pkg::rem_t'(lzss_pkg::POS_BITS);
					end
				end
				ST_LIT: begin
					acc_nx = acc_sh;
					rem_nx = rem_dec;
					if (rem_dec == '0) begin
						tok_set     = 1'b1;
						tok_nx.kind = lzss_pkg::TOK_LIT;
						tok_nx.lit  = acc_sh[lzss_pkg::LIT_BITS-1:0];
						stage_nx    = ST_FLAG;
						acc_nx      = '0;
					end
				end
				ST_POS: begin
					acc_nx = acc_sh;
					rem_nx = rem_dec;
					if (rem_dec == '0) begin
						acc_nx = '0;
						if (acc_sh == '0) begin
							// End marker: drop the rest of this byte.
							tok_set     = 1'b1;
							tok_nx.kind = lzss_pkg::TOK_END;
							stage_nx    = ST_FLAG;
							bits_nx     = '0;
						end else begin
							saved_nx = acc_sh;
							stage_nx = ST_LEN;
							rem_nx   = lzss_pkg::rem_t'(lzss_pkg::LEN_BITS);
						end
					end
				end
				ST_LEN: begin
					acc_nx = acc_sh;
					rem_nx = rem_dec;
					if (rem_dec == '0) begin
						tok_set     = 1'b1;
						tok_nx.kind = lzss_pkg::TOK_MATCH;
						tok_nx.pos  = saved_q;
						tok_nx.len  = acc_sh[lzss_pkg::LEN_BITS-1:0];
						stage_nx    = ST_FLAG;
						acc_nx      = '0;
					end
				end
				default: stage_nx = ST_FLAG;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ST_FLAG;
			bits_q      <= '0;
			acc_q       <= '0;
			rem_q       <= '0;
			saved_q     <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			stage_q <= stage_nx;
			bits_q  <= bits_nx;
			acc_q   <= acc_nx;
			rem_q   <= rem_nx;
			saved_q <= saved_nx;
			if (tok_set)
				tok_valid_q <= 1'b1;
			else if (tok_ready)
				tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		sh_q  <= sh_nx;
		tok_q <= tok_nx;
	end

endmodule
`default_nettype wire

FILE: hdl/lzss_bitstream_decoder.sv
// Top level of the LZSS bitstream decoder: copy control, write pointer and output register.
//
// Input channel (in_valid/in_ready/in_byte): one compressed byte per beat, bits read
// most significant first. The bit reader walks one bit per cycle unless a token waits, so
// in_ready stays low after a beat until its bits are walked or an end marker drops the tail.
// Output channel (out_valid/out_ready): one decompressed byte per beat, with
// last_of_run on the final result caused by a token and stream_end (byte zero) on
// the end-marker result.
// A literal enters the output register when its token is taken. A match of
// length L+3 issues one dictionary read per cycle while the output slot is free; each
// read passes the RAM's registered read stage before the output register, one
// byte per cycle. The single RAM port pair (one read, one write per cycle) sets that
// rate; the next token is taken once the last byte has left the read stage, so a full
// 18-byte match holds the copy path. Parsing of the next input byte runs in parallel.
// When the receiver stalls, the output register holds its beat, the pending RAM read
// data is held, and no further reads are issued; the bit reader stops while a finished
// token waits to be taken, and in_ready stays low until that byte's bits are walked.
// Reset clears control state at once; the dictionary needs no clearing pass, since a
// fill mark makes never-written entries read as zero. Write position restarts at one.
`timescale 1ns / 1ps
`default_nettype none
module lzss_bitstream_decoder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lzss_pkg::byte_t in_byte,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lzss_pkg::byte_t      out_byte,
	output logic                 last_of_run,
	output logic                 stream_end
);

	logic            tok_valid;
	logic            tok_ready;
	lzss_pkg::tok_t  tok;

	lzss_pkg::addr_t wp_q;
	lzss_pkg::addr_t src_q;
	lzss_pkg::cnt_t  rem_q;
	logic            rd_v_s1;
	logic            last_s1;

	logic            out_valid_q;
	lzss_pkg::byte_t out_byte_q;
	logic            last_q;
	logic            end_q;

	logic            slot;
	logic            consume;
	logic            issue;
	logic            tok_take;
	logic            take_lit;
	logic            take_match;
	logic            take_end;
	logic            we;
	lzss_pkg::byte_t wdata;
	lzss_pkg::byte_t rdata;

	lzss_bit_reader u_reader (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.in_ready  (in_ready),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_ready (tok_ready)
	);

	lzss_history u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (wp_q),
		.wdata  (wdata),
		.re     (issue),
		.raddr  (src_q),
		.rdata  (rdata)
	);

	// Output slot is free when empty or being drained this cycle.
	assign slot    = !out_valid_q || out_ready;
	assign consume = rd_v_s1 && slot;
	// Issue the next read when no data is pending or the pending data leaves this cycle.
	assign issue   = (rem_q != '0) && (!rd_v_s1 || consume);

	// Take a token only with the copy pipe empty; literal and end need the slot.
	assign tok_ready  = (rem_q == '0) && !rd_v_s1 &&
		((tok.kind == lzss_pkg::TOK_MATCH) || slot);
	assign tok_take   = tok_valid && tok_ready;
	assign take_lit   = tok_take && (tok.kind == lzss_pkg::TOK_LIT);
	assign take_match = tok_take && (tok.kind == lzss_pkg::TOK_MATCH);
	assign take_end   = tok_take && (tok.kind == lzss_pkg::TOK_END);

	assign we    = consume || take_lit;
	assign wdata = consume ? rdata : tok.lit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= lzss_pkg::addr_t'(1);
			rem_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (we)
				wp_q <= wp_q + lzss_pkg::addr_t'(1);
			else if (take_end)
				wp_q <= lzss_pkg::addr_t'(1);

			if (take_match)
				rem_q <= lzss_pkg::cnt_t'(tok.len) + lzss_pkg::cnt_t'(lzss_pkg::MIN_MATCH);
			else if (issue)
				rem_q <= rem_q - lzss_pkg::cnt_t'(1);

			if (issue)
				rd_v_s1 <= 1'b1;
			else if (consume)
				rd_v_s1 <= 1'b0;

			if (consume || take_lit || take_end)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_match)
			src_q <= tok.pos;
		else if (issue)
			src_q <= src_q + lzss_pkg::addr_t'(1);

		if (issue)
			last_s1 <= (rem_q == lzss_pkg::cnt_t'(1));

		if (consume) begin
			out_byte_q <= rdata;
			last_q     <= last_s1;
			end_q      <= 1'b0;
		end else if (take_lit) begin
			out_byte_q <= tok.lit;
			last_q     <= 1'b1;
			end_q      <= 1'b0;
		end else if (take_end) begin
			out_byte_q <= '0;
			last_q     <= 1'b1;
			end_q      <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign stream_end  = end_q;

endmodule
`default_nettype wire
